/* src/cptg_pkg.sv */
// Package for the cubic point-to-point trajectory generator.
// Holds the request/response word types, action codes and register indexes.
// No dependencies.
package cptg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int AXES      = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 31;

    localparam logic [31:0] TICK_STEP = 32'd655;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VMAX_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VMAX_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VMAX_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMAX_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AMAX_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AMAX_THREE = 3'd5;

    localparam logic [CFG_W-1:0] CFG_RESET = 31'd65536;

    typedef struct packed {
        logic               action;
        logic signed [31:0] start_angle_one;
        logic signed [31:0] start_angle_two;
        logic signed [31:0] start_angle_three;
        logic signed [31:0] goal_angle_one;
        logic signed [31:0] goal_angle_two;
        logic signed [31:0] goal_angle_three;
    } req_t;

    typedef struct packed {
        logic signed [31:0] position_one;
        logic signed [31:0] position_two;
        logic signed [31:0] position_three;
        logic signed [31:0] speed_one;
        logic signed [31:0] speed_two;
        logic signed [31:0] speed_three;
        logic [30:0]        move_duration;
        logic               sample_valid;
        logic               last_sample;
    } rsp_t;

endpackage

/* src/cubic_p2p_trajectory_generator.sv */
// Three-axis cubic point-to-point trajectory generator, Q16.16 fixed point.
// One sequencer around a shared divide/square-root step and a shift-add multiplier.
// Depends on cptg_pkg.
//
// Usage:
//   req channel (req_valid/req_stall/req_word) takes one word per command:
//   action START loads a move from start and goal angles, action TICK
//   advances time by one step and yields a sample while a move is active.
//   rsp channel (rsp_valid/rsp_stall/rsp_word) returns exactly one word per
//   request. cfg_wr_en/cfg_index/cfg_data write the six speed/accel limits;
//   write them only while the block is idle.
// Sequencing (one command at a time, req_stall high meanwhile):
//   START: per axis up to a speed divide, an accel divide and a root,
//          then five coefficient divides per axis on the same unit.
//   TICK while moving: two multiplies for t^2 and t^3, then four per
//          axis. TICK with no move active returns a zero sample at once.
//   Divide, root and multiply all step through the one shared unit.
// Reset: limits return to 1.0, move time to one LSB, no move in progress.
// A stalled response holds the word and keeps req_stall high until taken.
module cubic_p2p_trajectory_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  cptg_pkg::req_t                    req_word,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output cptg_pkg::rsp_t                    rsp_word,
    input  logic                              cfg_wr_en,
    input  logic [cptg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cptg_pkg::CFG_W-1:0]        cfg_data
);
    import cptg_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_TV   = 4'd1;   // speed-limited time
    localparam logic [3:0] ST_TA   = 4'd2;   // accel quotient
    localparam logic [3:0] ST_SQ   = 4'd3;   // accel root
    localparam logic [3:0] ST_AXN  = 4'd4;   // next axis / floor of move time
    localparam logic [3:0] ST_G2   = 4'd5;   // square coefficient growth
    localparam logic [3:0] ST_G3   = 4'd6;   // cube coefficient growth
    localparam logic [3:0] ST_T2   = 4'd7;
    localparam logic [3:0] ST_T3   = 4'd8;
    localparam logic [3:0] ST_PA   = 4'd9;
    localparam logic [3:0] ST_PB   = 4'd10;
    localparam logic [3:0] ST_VA   = 4'd11;
    localparam logic [3:0] ST_VB   = 4'd12;
    localparam logic [3:0] ST_AXO  = 4'd13;

    // shared unit modes
    localparam logic [1:0] MODE_DIV  = 2'd0;
    localparam logic [1:0] MODE_SQRT = 2'd1;
    localparam logic [1:0] MODE_MUL  = 2'd2;

    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd31;
    localparam logic [6:0] MUL_STEPS  = 7'd64;

    localparam logic [1:0]  AX_LAST  = 2'(AXES - 1);
    localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;
    localparam logic [62:0] COEF_LIM = 63'h1 << 47;
    localparam logic [46:0] COEF_MAX = {47{1'b1}};
    localparam logic [63:0] Q_LIM    = 64'h1 << (62 - FRAC_BITS);
    localparam logic [63:0] TERM_LIM = 64'h1 << 60;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    function automatic logic [33:0] mul3(input logic [31:0] v);
        return {2'b00, v} + {1'b0, v, 1'b0};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > S32_MAX)
        begin
            r = S32_MAX;
        end
        else if (v < S32_MIN)
        begin
            r = S32_MIN;
        end
        return r[31:0];
    endfunction

    // control state
    logic [3:0]        state_reg, state_next;
    logic              wait_reg, wait_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [1:0]        mode_reg, mode_next;
    logic [1:0]        ax_reg, ax_next;
    logic [1:0]        gcnt_reg, gcnt_next;
    logic              active_reg, active_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [CFG_W-1:0]  vmax_reg [AXES];
    logic [CFG_W-1:0]  vmax_next [AXES];
    logic [CFG_W-1:0]  amax_reg [AXES];
    logic [CFG_W-1:0]  amax_next [AXES];
    logic [30:0]       total_reg, total_next;
    logic [31:0]       elapsed_reg, elapsed_next;

    // per-axis move data
    logic [31:0]        dmag_reg [AXES];
    logic [31:0]        dmag_next [AXES];
    logic               neg_reg [AXES];
    logic               neg_next [AXES];
    logic               up_reg [AXES];
    logic               up_next [AXES];
    logic signed [31:0] base_reg [AXES];
    logic signed [31:0] base_next [AXES];
    logic signed [31:0] tgt_reg [AXES];
    logic signed [31:0] tgt_next [AXES];
    logic [46:0]        a2_reg [AXES];
    logic [46:0]        a2_next [AXES];
    logic [46:0]        a3_reg [AXES];
    logic [46:0]        a3_next [AXES];
    logic signed [31:0] pos_reg [AXES];
    logic signed [31:0] pos_next [AXES];
    logic signed [31:0] vel_reg [AXES];
    logic signed [31:0] vel_next [AXES];

    // working registers
    logic [62:0]        m_reg, m_next;
    logic [47:0]        t2_reg, t2_next;
    logic [60:0]        t3_reg, t3_next;
    logic signed [63:0] pacc_reg, pacc_next;
    logic signed [63:0] vacc_reg, vacc_next;
    logic               smp_reg, smp_next;
    logic               last_reg, last_next;

    // shared unit
    logic [31:0] rem_reg, rem_next;
    logic [63:0] num_reg, num_next;
    logic [31:0] root_reg, root_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [47:0] mcand_reg, mcand_next;
    logic [63:0] mplier_reg, mplier_next;
    logic [79:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;

    logic        accept;
    logic        done;
    logic [34:0] cmp_a, cmp_b;
    logic [35:0] diff;
    logic        ge;
    logic [81:0] mul_sum;
    logic [63:0] mul_sh;
    logic [60:0] mres;
    logic [63:0] term;

    assign req_stall = (state_reg != ST_IDLE) || rsp_valid_reg;
    assign accept    = req_valid && !req_stall;
    assign done      = wait_reg && (cnt_reg == 7'd0);
    assign rsp_valid = rsp_valid_reg;

    // one compare/subtract shared by the divide and root steps
    always_comb
    begin
        if (mode_reg == MODE_SQRT)
        begin
            cmp_a = {1'b0, rem_reg, num_reg[63:62]};
            cmp_b = {1'b0, root_reg, 2'b01};
        end
        else
        begin
            cmp_a = {2'b00, rem_reg, num_reg[63]};
            cmp_b = {3'b000, dvs_reg};
        end
        diff = {1'b0, cmp_a} - {1'b0, cmp_b};
        ge   = !diff[35];
    end

    // shift-add multiply; the product shifted down by F saturates at 2^60
    always_comb
    begin
        mul_sum = {1'b0, acc_reg, 1'b0} + (mplier_reg[63] ? {34'd0, mcand_reg} : 82'd0);
        mul_sh  = acc_reg[79:FRAC_BITS];
        if (ovf_reg || (mul_sh > TERM_LIM))
        begin
            mres = TERM_LIM[60:0];
        end
        else
        begin
            mres = mul_sh[60:0];
        end
        term = {3'b000, mres};
    end

    always_comb
    begin
        logic [32:0]        dif;
        logic signed [31:0] s_ang;
        logic signed [31:0] g_ang;
        logic [32:0]        esum;
        logic [30:0]        tval;
        logic [33:0]        d3;
        logic               g_fire;
        logic [62:0]        g_val;
        logic               g_last;
        logic [46:0]        g_cap;
        logic signed [31:0] pos;
        logic               lst;
        logic [1:0]         ax_inc;

        state_next     = state_reg;
        wait_next      = wait_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        ax_next        = ax_reg;
        gcnt_next      = gcnt_reg;
        active_next    = active_reg;
        rsp_valid_next = rsp_valid_reg;
        vmax_next      = vmax_reg;
        amax_next      = amax_reg;
        total_next     = total_reg;
        elapsed_next   = elapsed_reg;
        dmag_next      = dmag_reg;
        neg_next       = neg_reg;
        up_next        = up_reg;
        base_next      = base_reg;
        tgt_next       = tgt_reg;
        a2_next        = a2_reg;
        a3_next        = a3_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        m_next         = m_reg;
        t2_next        = t2_reg;
        t3_next        = t3_reg;
        pacc_next      = pacc_reg;
        vacc_next      = vacc_reg;
        smp_next       = smp_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        root_next      = root_reg;
        dvs_next       = dvs_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;

        dif    = 33'd0;
        s_ang  = 32'sd0;
        g_ang  = 32'sd0;
        esum   = {1'b0, elapsed_reg} + {1'b0, TICK_STEP};
        tval   = 31'd0;
        d3     = mul3(dmag_reg[ax_reg]);
        g_fire = 1'b0;
        g_val  = 63'd0;
        g_last = (state_reg == ST_G2) ? (gcnt_reg == 2'd1) : (gcnt_reg == 2'd2);
        g_cap  = 47'd0;
        pos    = 32'sd0;
        lst    = 1'b0;
        ax_inc = ax_reg + 2'd1;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_VMAX_ONE:   vmax_next[0] = cfg_data;
                CFG_VMAX_TWO:   vmax_next[1] = cfg_data;
                CFG_VMAX_THREE: vmax_next[2] = cfg_data;
                CFG_AMAX_ONE:   amax_next[0] = cfg_data;
                CFG_AMAX_TWO:   amax_next[1] = cfg_data;
                CFG_AMAX_THREE: amax_next[2] = cfg_data;
                default: ;
            endcase
        end

        // one step of the shared unit
        if (cnt_reg != 7'd0)
        begin
            cnt_next = cnt_reg - 7'd1;
            case (mode_reg)
                MODE_DIV:
                begin
                    rem_next = ge ? diff[31:0] : cmp_a[31:0];
                    num_next = {num_reg[62:0], ge};
                end
                MODE_SQRT:
                begin
                    rem_next  = ge ? diff[31:0] : cmp_a[31:0];
                    num_next  = {num_reg[61:0], 2'b00};
                    root_next = {root_reg[30:0], ge};
                end
                MODE_MUL:
                begin
                    acc_next    = mul_sum[79:0];
                    ovf_next    = ovf_reg || (mul_sum[81:80] != 2'b00);
                    mplier_next = {mplier_reg[62:0], 1'b0};
                end
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_word.action == ACT_START)
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            case (i)
                                0:
                                begin
                                    s_ang = req_word.start_angle_one;
                                    g_ang = req_word.goal_angle_one;
                                end
                                1:
                                begin
                                    s_ang = req_word.start_angle_two;
                                    g_ang = req_word.goal_angle_two;
                                end
                                default:
                                begin
                                    s_ang = req_word.start_angle_three;
                                    g_ang = req_word.goal_angle_three;
                                end
                            endcase
                            dif = {g_ang[31], g_ang} - {s_ang[31], s_ang};
                            neg_next[i]  = dif[32];
                            dmag_next[i] = dif[32] ? 32'(-dif) : dif[31:0];
                            up_next[i]   = g_ang > s_ang;
                            base_next[i] = s_ang;
                            tgt_next[i]  = g_ang;
                        end
                        active_next = 1'b0;
                        total_next  = 31'd0;
                        ax_next     = 2'd0;
                        wait_next   = 1'b0;
                        state_next  = ST_TV;
                    end
                    else if (active_reg)
                    begin
                        elapsed_next = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
                        wait_next    = 1'b0;
                        state_next   = ST_T2;
                    end
                    else
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            pos_next[i] = 32'sd0;
                            vel_next[i] = 32'sd0;
                        end
                        smp_next       = 1'b0;
                        last_next      = 1'b0;
                        rsp_valid_next = 1'b1;
                    end
                end
            end

            ST_TV:
            begin
                if (!wait_reg)
                begin
                    if (vmax_reg[ax_reg] == '0)
                    begin
                        state_next = ST_TA;
                    end
                    else
                    begin
                        num_next  = {14'd0, d3, 16'd0};
                        dvs_next  = {vmax_reg[ax_reg], 1'b0};
                        rem_next  = 32'd0;
                        mode_next = MODE_DIV;
                        cnt_next  = DIV_STEPS;
                        wait_next = 1'b1;
                    end
                end
                else if (done)
                begin
                    tval = (num_reg > {33'd0, TIME_MAX}) ? TIME_MAX : num_reg[30:0];
                    if (tval > total_reg)
                    begin
                        total_next = tval;
                    end
                    wait_next  = 1'b0;
                    state_next = ST_TA;
                end
            end

            ST_TA:
            begin
                if (!wait_reg)
                begin
                    if (amax_reg[ax_reg] == '0)
                    begin
                        state_next = ST_AXN;
                    end
                    else
                    begin
                        num_next  = {13'd0, d3, 17'd0};
                        dvs_next  = {1'b0, amax_reg[ax_reg]};
                        rem_next  = 32'd0;
                        mode_next = MODE_DIV;
                        cnt_next  = DIV_STEPS;
                        wait_next = 1'b1;
                    end
                end
                else if (done)
                begin
                    if (num_reg >= Q_LIM)
                    begin
                        total_next = TIME_MAX;
                        wait_next  = 1'b0;
                        state_next = ST_AXN;
                    end
                    else
                    begin
                        // root of q * 2^F, two operand bits per step
                        num_next   = {num_reg[45:0], 18'd0};
                        rem_next   = 32'd0;
                        root_next  = 32'd0;
                        mode_next  = MODE_SQRT;
                        cnt_next   = SQRT_STEPS;
                        state_next = ST_SQ;
                    end
                end
            end

            ST_SQ:
            begin
                if (done)
                begin
                    if (root_reg[30:0] > total_reg)
                    begin
                        total_next = root_reg[30:0];
                    end
                    wait_next  = 1'b0;
                    state_next = ST_AXN;
                end
            end

            ST_AXN:
            begin
                if (ax_reg == AX_LAST)
                begin
                    if (total_reg == 31'd0)
                    begin
                        total_next = 31'd1;
                    end
                    ax_next    = 2'd0;
                    m_next     = {29'd0, mul3(dmag_reg[0])};
                    gcnt_next  = 2'd0;
                    state_next = ST_G2;
                end
                else
                begin
                    ax_next    = ax_inc;
                    state_next = ST_TV;
                end
            end

            ST_G2, ST_G3:
            begin
                if (!wait_reg)
                begin
                    if (m_reg >= COEF_LIM)
                    begin
                        g_fire = 1'b1;
                        g_val  = COEF_LIM;
                    end
                    else
                    begin
                        num_next  = {1'b0, m_reg[46:0], 16'd0};
                        dvs_next  = {1'b0, total_reg};
                        rem_next  = 32'd0;
                        mode_next = MODE_DIV;
                        cnt_next  = DIV_STEPS;
                        wait_next = 1'b1;
                    end
                end
                else if (done)
                begin
                    g_fire    = 1'b1;
                    g_val     = num_reg[62:0];
                    wait_next = 1'b0;
                end

                if (g_fire)
                begin
                    if (g_last)
                    begin
                        g_cap     = (g_val > {16'd0, COEF_MAX}) ? COEF_MAX : g_val[46:0];
                        gcnt_next = 2'd0;
                        if (state_reg == ST_G2)
                        begin
                            a2_next[ax_reg] = g_cap;
                            m_next          = {30'd0, dmag_reg[ax_reg], 1'b0};
                            state_next      = ST_G3;
                        end
                        else
                        begin
                            a3_next[ax_reg] = g_cap;
                            if (ax_reg == AX_LAST)
                            begin
                                active_next  = 1'b1;
                                elapsed_next = 32'd0;
                                for (int i = 0; i < AXES; i++)
                                begin
                                    pos_next[i] = 32'sd0;
                                    vel_next[i] = 32'sd0;
                                end
                                smp_next       = 1'b0;
                                last_next      = 1'b0;
                                rsp_valid_next = 1'b1;
                                state_next     = ST_IDLE;
                            end
                            else
                            begin
                                ax_next    = ax_inc;
                                m_next     = {29'd0, mul3(dmag_reg[ax_inc])};
                                state_next = ST_G2;
                            end
                        end
                    end
                    else
                    begin
                        m_next    = g_val;
                        gcnt_next = gcnt_reg + 2'd1;
                    end
                end
            end

            ST_T2, ST_T3, ST_PA, ST_PB, ST_VA, ST_VB:
            begin
                if (!wait_reg)
                begin
                    case (state_reg)
                        ST_T2:
                        begin
                            mcand_next  = {16'd0, elapsed_reg};
                            mplier_next = {32'd0, elapsed_reg};
                        end
                        ST_T3:
                        begin
                            mcand_next  = t2_reg;
                            mplier_next = {32'd0, elapsed_reg};
                        end
                        ST_PA:
                        begin
                            mcand_next  = {1'b0, a2_reg[ax_reg]};
                            mplier_next = {16'd0, t2_reg};
                        end
                        ST_PB:
                        begin
                            mcand_next  = {1'b0, a3_reg[ax_reg]};
                            mplier_next = {3'd0, t3_reg};
                        end
                        ST_VA:
                        begin
                            mcand_next  = {1'b0, a2_reg[ax_reg]};
                            mplier_next = {32'd0, elapsed_reg};
                        end
                        default:
                        begin
                            mcand_next  = {1'b0, a3_reg[ax_reg]};
                            mplier_next = {16'd0, t2_reg};
                        end
                    endcase
                    acc_next  = 80'd0;
                    ovf_next  = 1'b0;
                    mode_next = MODE_MUL;
                    cnt_next  = MUL_STEPS;
                    wait_next = 1'b1;
                end
                else if (done)
                begin
                    wait_next = 1'b0;
                    case (state_reg)
                        ST_T2:
                        begin
                            t2_next    = mres[47:0];
                            state_next = ST_T3;
                        end
                        ST_T3:
                        begin
                            t3_next    = mres;
                            ax_next    = 2'd0;
                            pacc_next  = 64'(base_reg[0]);
                            vacc_next  = 64'sd0;
                            state_next = ST_PA;
                        end
                        ST_PA:
                        begin
                            // square term carries the sign of the move
                            pacc_next  = neg_reg[ax_reg] ? pacc_reg - $signed(term)
                                                         : pacc_reg + $signed(term);
                            state_next = ST_PB;
                        end
                        ST_PB:
                        begin
                            // cube term opposes it
                            pacc_next  = neg_reg[ax_reg] ? pacc_reg + $signed(term)
                                                         : pacc_reg - $signed(term);
                            state_next = ST_VA;
                        end
                        ST_VA:
                        begin
                            vacc_next  = neg_reg[ax_reg]
                                         ? vacc_reg - $signed({term[62:0], 1'b0})
                                         : vacc_reg + $signed({term[62:0], 1'b0});
                            state_next = ST_VB;
                        end
                        default:
                        begin
                            vacc_next  = neg_reg[ax_reg]
                                         ? vacc_reg + $signed(term + {term[62:0], 1'b0})
                                         : vacc_reg - $signed(term + {term[62:0], 1'b0});
                            state_next = ST_AXO;
                        end
                    endcase
                end
            end

            ST_AXO:
            begin
                pos = sat32(pacc_reg);
                if (up_reg[ax_reg] && (pos > tgt_reg[ax_reg]))
                begin
                    pos = tgt_reg[ax_reg];
                end
                pos_next[ax_reg] = pos;
                vel_next[ax_reg] = sat32(vacc_reg);
                if (ax_reg == AX_LAST)
                begin
                    lst            = elapsed_reg > {1'b0, total_reg};
                    last_next      = lst;
                    smp_next       = 1'b1;
                    active_next    = !lst;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    ax_next    = ax_inc;
                    pacc_next  = 64'(base_reg[ax_inc]);
                    vacc_next  = 64'sd0;
                    state_next = ST_PA;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
                wait_next  = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= 1'b0;
            cnt_reg       <= 7'd0;
            mode_reg      <= MODE_DIV;
            ax_reg        <= 2'd0;
            gcnt_reg      <= 2'd0;
            active_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            total_reg     <= 31'd1;
            elapsed_reg   <= 32'd0;
            for (int i = 0; i < AXES; i++)
            begin
                vmax_reg[i] <= CFG_RESET;
                amax_reg[i] <= CFG_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
            ax_reg        <= ax_next;
            gcnt_reg      <= gcnt_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
            total_reg     <= total_next;
            elapsed_reg   <= elapsed_next;
            vmax_reg      <= vmax_next;
            amax_reg      <= amax_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dmag_reg   <= dmag_next;
        neg_reg    <= neg_next;
        up_reg     <= up_next;
        base_reg   <= base_next;
        tgt_reg    <= tgt_next;
        a2_reg     <= a2_next;
        a3_reg     <= a3_next;
        pos_reg    <= pos_next;
        vel_reg    <= vel_next;
        m_reg      <= m_next;
        t2_reg     <= t2_next;
        t3_reg     <= t3_next;
        pacc_reg   <= pacc_next;
        vacc_reg   <= vacc_next;
        smp_reg    <= smp_next;
        last_reg   <= last_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        root_reg   <= root_next;
        dvs_reg    <= dvs_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        ovf_reg    <= ovf_next;
    end

    always_comb
    begin
        rsp_word.position_one   = pos_reg[0];
        rsp_word.position_two   = pos_reg[1];
        rsp_word.position_three = pos_reg[2];
        rsp_word.speed_one      = vel_reg[0];
        rsp_word.speed_two      = vel_reg[1];
        rsp_word.speed_three    = vel_reg[2];
        rsp_word.move_duration  = total_reg;
        rsp_word.sample_valid   = smp_reg;
        rsp_word.last_sample    = last_reg;
    end

endmodule
